### hw/rtl/b2d_pkg.sv
package b2d_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// Decimal digits needed for an unsigned number of w bits: floor(w*log10(2)) + 1.
	function automatic int digits_for(input int w);
		return (w * 1233) / 4096 + 1;
	endfunction

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic convert;
		logic shift_digit;
	} cmd_t;

	typedef struct packed {
		logic bits_last;
		logic top_nonzero;
		logic one_left;
	} status_t;

endpackage

### hw/rtl/b2d_ctrl.sv
module b2d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  b2d_pkg::status_t status,
	output b2d_pkg::cmd_t    cmd
);

	b2d_pkg::state_t state_q;
	b2d_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2d_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			b2d_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = b2d_pkg::ST_CONVERT;
				end
			end
			b2d_pkg::ST_CONVERT: begin
				if (status.bits_last) begin
					state_next = b2d_pkg::ST_SKIP;
				end
			end
			b2d_pkg::ST_SKIP: begin
				if (status.top_nonzero || status.one_left) begin
					state_next = b2d_pkg::ST_EMIT;
				end
			end
			b2d_pkg::ST_EMIT: begin
				if (out_ready && status.one_left) begin
					state_next = b2d_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = b2d_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		out_valid       = 1'b0;
		cmd.load        = 1'b0;
		cmd.convert     = 1'b0;
		cmd.shift_digit = 1'b0;
		case (state_q)
			b2d_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			b2d_pkg::ST_CONVERT: begin
				cmd.convert = 1'b1;
			end
			b2d_pkg::ST_SKIP: begin
				// drop leading zero digits, keep at least one
				cmd.shift_digit = !(status.top_nonzero || status.one_left);
			end
			b2d_pkg::ST_EMIT: begin
				out_valid       = 1'b1;
				cmd.shift_digit = out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/b2d_datapath.sv
module b2d_datapath #(
	parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic [VALUE_WIDTH-1:0] value,
	input  b2d_pkg::cmd_t          cmd,
	output b2d_pkg::status_t       status,
	output logic [3:0]             digit,
	output logic                   last_digit
);

	localparam int DIGITS  = b2d_pkg::digits_for(VALUE_WIDTH);
	localparam int BCD_W   = DIGITS * 4;
	localparam int BITS_W  = $clog2(VALUE_WIDTH + 1);
	localparam int DCNT_W  = $clog2(DIGITS + 1);

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BITS_W-1:0]      bits_q;
	logic [DCNT_W-1:0]      dcnt_q;
	logic [BCD_W-1:0]       bcd_adj;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q  <= value;
			bcd_q  <= '0;
			bits_q <= BITS_W'(VALUE_WIDTH);
			dcnt_q <= DCNT_W'(DIGITS);
		end else if (cmd.convert) begin
			bin_q  <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q  <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
			bits_q <= bits_q - BITS_W'(1);
		end else if (cmd.shift_digit) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'b0000};
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end
	end

	assign status.bits_last   = (bits_q == BITS_W'(1));
	assign status.top_nonzero = (bcd_q[BCD_W-1 -: 4] != 4'd0);
	assign status.one_left    = (dcnt_q == DCNT_W'(1));

	assign digit      = bcd_q[BCD_W-1 -: 4];
	assign last_digit = status.one_left;

endmodule

### hw/rtl/binary_to_decimal_digit_stream.sv
// After accept, a shift-and-add-3 loop converts the VALUE_WIDTH bits, then
// leading zeros are dropped, then one digit per cycle out while out_ready is high.
// A new number is taken only once the last digit of the one before has gone out;
// the bit-serial conversion loop handles one bit per cycle.
// Reset (arst_n low, asynchronous) returns the controller to idle; no item is kept.
module binary_to_decimal_digit_stream #(
	parameter int VALUE_WIDTH = b2d_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             digit,
	output logic                   last_digit
);

	b2d_pkg::cmd_t    cmd;
	b2d_pkg::status_t status;

	b2d_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	b2d_datapath #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_datapath (
		.clk        (clk),
		.value      (value),
		.cmd        (cmd),
		.status     (status),
		.digit      (digit),
		.last_digit (last_digit)
	);

endmodule
